### rtl/core/prg_pkg.sv
// prg_pkg: shared types, widths and register codes of the pinhole ray generator
// used by prg_csr, prg_cam, prg_rot and pinhole_ray_generator
`timescale 1ns / 1ps
`default_nettype none

package prg_pkg;

   // pixel index width
   localparam int COORD_BITS = 12;

   // pixel index in q.4
   localparam int PIX_Q_BITS = COORD_BITS + 4;
   // signed offset from the principal point
   localparam int OFS_BITS   = ((PIX_Q_BITS > 16) ? PIX_Q_BITS : 16) + 2;
   localparam int RCP_BITS   = 24;
   // camera direction in q.28, signed
   localparam int CAM_BITS   = OFS_BITS + RCP_BITS + 1;
   localparam int ROT_BITS   = 16;
   localparam int PROD_BITS  = CAM_BITS + ROT_BITS;
   localparam int ACC_BITS   = PROD_BITS + 2;
   localparam int DIR_BITS   = 16;
   // z of the camera direction is -(1 << Z_SHIFT)
   localparam int Z_SHIFT    = 28;
   // q.42 down to q4.12
   localparam int DIR_SHIFT  = 30;

   // configuration port
   localparam int CSR_DATA_BITS  = 64;
   localparam int REG_WORD_BITS  = 3;
   localparam int REG_INDEX_BITS = 3;
   localparam int CSR_ADDR_BITS  = REG_INDEX_BITS + REG_WORD_BITS;

   localparam logic [REG_INDEX_BITS-1:0] REG_ROT_ROW0    = 3'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_ROT_ROW1    = 3'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_ROT_ROW2    = 3'd2;
   localparam logic [REG_INDEX_BITS-1:0] REG_TRANSLATION = 3'd3;
   localparam logic [REG_INDEX_BITS-1:0] REG_CENTER_X    = 3'd4;
   localparam logic [REG_INDEX_BITS-1:0] REG_CENTER_Y    = 3'd5;
   localparam logic [REG_INDEX_BITS-1:0] REG_INV_FOCAL_X = 3'd6;
   localparam logic [REG_INDEX_BITS-1:0] REG_INV_FOCAL_Y = 3'd7;

   // reset values: identity rotation, origin at zero
   localparam logic [47:0] ROT_ROW0_RESET    = 48'd16384;
   localparam logic [47:0] ROT_ROW1_RESET    = 48'd1073741824;
   localparam logic [47:0] ROT_ROW2_RESET    = 48'd70368744177664;
   localparam logic [47:0] TRANSLATION_RESET = 48'd0;
   localparam logic [15:0] CENTER_RESET      = 16'd3200;
   localparam logic [23:0] INV_FOCAL_RESET   = 24'd44779;

   typedef struct packed {
      logic [47:0]         rot_row0;
      logic [47:0]         rot_row1;
      logic [47:0]         rot_row2;
      logic [47:0]         translation;
      logic [15:0]         center_x;
      logic [15:0]         center_y;
      logic [RCP_BITS-1:0] inv_focal_x;
      logic [RCP_BITS-1:0] inv_focal_y;
   } prg_cfg_type;

endpackage

`default_nettype wire

### rtl/core/pinhole_ray_generator.sv
// pinhole_ray_generator: one world-space camera ray per pixel transfer
// five register stages from request transfer to rsp_valid: offset,
// reciprocal scale, rotation products, sum and round, saturate into the output register
// throughput one ray per cycle while rsp_ready is high; every stage holds its own
// valid and takes a new item once it is empty or its successor moves on
// synchronous active-high reset empties the pipeline and loads identity rotation,
// zero origin, principal point 200.0 and the default reciprocal focal lengths
// depends on prg_pkg, prg_csr, prg_cam, prg_rot
`timescale 1ns / 1ps
`default_nettype none

module pinhole_ray_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [prg_pkg::COORD_BITS-1:0]     req_pixel_row,
   input  wire logic [prg_pkg::COORD_BITS-1:0]     req_pixel_col,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [15:0]                      rsp_origin_x,
   output logic signed [15:0]                      rsp_origin_y,
   output logic signed [15:0]                      rsp_origin_z,
   output logic signed [prg_pkg::DIR_BITS-1:0]     rsp_dir_x,
   output logic signed [prg_pkg::DIR_BITS-1:0]     rsp_dir_y,
   output logic signed [prg_pkg::DIR_BITS-1:0]     rsp_dir_z,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [prg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [prg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [prg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                    csr_pready
);
   import prg_pkg::*;

   prg_cfg_type                cfg;
   logic                       cam_valid;
   logic                       cam_ready;
   logic signed [CAM_BITS-1:0] cam_x;
   logic signed [CAM_BITS-1:0] cam_y;

   prg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   prg_cam u_cam (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .pixel_row (req_pixel_row),
      .pixel_col (req_pixel_col),
      .out_valid (cam_valid),
      .out_ready (cam_ready),
      .cam_x     (cam_x),
      .cam_y     (cam_y)
   );

   prg_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (cam_valid),
      .in_ready  (cam_ready),
      .cam_x     (cam_x),
      .cam_y     (cam_y),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .dir_x     (rsp_dir_x),
      .dir_y     (rsp_dir_y),
      .dir_z     (rsp_dir_z)
   );

   // origin = translation; user changes it only while the block is idle, unenforced
   assign rsp_origin_x = $signed(cfg.translation[15:0]);
   assign rsp_origin_y = $signed(cfg.translation[31:16]);
   assign rsp_origin_z = $signed(cfg.translation[47:32]);

endmodule

`default_nettype wire

### rtl/core/prg_csr.sv
// prg_csr: configuration registers with an apb-style slave port
// depends on prg_pkg
`timescale 1ns / 1ps
`default_nettype none

module prg_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [prg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [prg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [prg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                    csr_pready,
   output prg_pkg::prg_cfg_type                    cfg
);
   import prg_pkg::*;

   prg_cfg_type                cfg_ff;
   logic                       wr_en;
   logic [REG_INDEX_BITS-1:0]  reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[CSR_ADDR_BITS-1:REG_WORD_BITS];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_row0    <= ROT_ROW0_RESET;
         cfg_ff.rot_row1    <= ROT_ROW1_RESET;
         cfg_ff.rot_row2    <= ROT_ROW2_RESET;
         cfg_ff.translation <= TRANSLATION_RESET;
         cfg_ff.center_x    <= CENTER_RESET;
         cfg_ff.center_y    <= CENTER_RESET;
         cfg_ff.inv_focal_x <= INV_FOCAL_RESET;
         cfg_ff.inv_focal_y <= INV_FOCAL_RESET;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_ROT_ROW0:    cfg_ff.rot_row0    <= csr_pwdata[47:0];
            REG_ROT_ROW1:    cfg_ff.rot_row1    <= csr_pwdata[47:0];
            REG_ROT_ROW2:    cfg_ff.rot_row2    <= csr_pwdata[47:0];
            REG_TRANSLATION: cfg_ff.translation <= csr_pwdata[47:0];
            REG_CENTER_X:    cfg_ff.center_x    <= csr_pwdata[15:0];
            REG_CENTER_Y:    cfg_ff.center_y    <= csr_pwdata[15:0];
            REG_INV_FOCAL_X: cfg_ff.inv_focal_x <= csr_pwdata[RCP_BITS-1:0];
            REG_INV_FOCAL_Y: cfg_ff.inv_focal_y <= csr_pwdata[RCP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ROT_ROW0:    csr_prdata = CSR_DATA_BITS'(cfg_ff.rot_row0);
         REG_ROT_ROW1:    csr_prdata = CSR_DATA_BITS'(cfg_ff.rot_row1);
         REG_ROT_ROW2:    csr_prdata = CSR_DATA_BITS'(cfg_ff.rot_row2);
         REG_TRANSLATION: csr_prdata = CSR_DATA_BITS'(cfg_ff.translation);
         REG_CENTER_X:    csr_prdata = CSR_DATA_BITS'(cfg_ff.center_x);
         REG_CENTER_Y:    csr_prdata = CSR_DATA_BITS'(cfg_ff.center_y);
         REG_INV_FOCAL_X: csr_prdata = CSR_DATA_BITS'(cfg_ff.inv_focal_x);
         REG_INV_FOCAL_Y: csr_prdata = CSR_DATA_BITS'(cfg_ff.inv_focal_y);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/prg_cam.sv
// prg_cam: camera-space direction, two stages (principal point offset, reciprocal scale)
// depends on prg_pkg
`timescale 1ns / 1ps
`default_nettype none

module prg_cam (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire prg_pkg::prg_cfg_type                 cfg,
   input  wire logic                                 in_valid,
   output logic                                      in_ready,
   input  wire logic [prg_pkg::COORD_BITS-1:0]       pixel_row,
   input  wire logic [prg_pkg::COORD_BITS-1:0]       pixel_col,
   output logic                                      out_valid,
   input  wire logic                                 out_ready,
   output logic signed [prg_pkg::CAM_BITS-1:0]       cam_x,
   output logic signed [prg_pkg::CAM_BITS-1:0]       cam_y
);
   import prg_pkg::*;

   logic                       ofs_v_ff;
   logic                       ofs_rdy;
   logic signed [OFS_BITS-1:0] ux_ff, ux_in;
   logic signed [OFS_BITS-1:0] uy_ff, uy_in;

   logic                       cam_v_ff;
   logic                       cam_rdy;
   logic signed [CAM_BITS-1:0] dx_ff, dx_in;
   logic signed [CAM_BITS-1:0] dy_ff, dy_in;

   assign cam_rdy  = !cam_v_ff || out_ready;
   assign ofs_rdy  = !ofs_v_ff || cam_rdy;
   assign in_ready = ofs_rdy;

   // pixel index to q.4, then offset from the principal point
   assign ux_in = $signed(OFS_BITS'({pixel_col, 4'b0000})) - $signed(OFS_BITS'(cfg.center_x));
   assign uy_in = $signed(OFS_BITS'(cfg.center_y)) - $signed(OFS_BITS'({pixel_row, 4'b0000}));

   // scale by the reciprocal focal lengths, q.4 * q0.24 = q.28
   assign dx_in = CAM_BITS'(ux_ff) * CAM_BITS'($signed({1'b0, cfg.inv_focal_x}));
   assign dy_in = CAM_BITS'(uy_ff) * CAM_BITS'($signed({1'b0, cfg.inv_focal_y}));

   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_v_ff <= 1'b0;
         cam_v_ff <= 1'b0;
      end else begin
         if (ofs_rdy) begin
            ofs_v_ff <= in_valid;
         end
         if (cam_rdy) begin
            cam_v_ff <= ofs_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ofs_rdy && in_valid) begin
         ux_ff <= ux_in;
         uy_ff <= uy_in;
      end
      if (cam_rdy && ofs_v_ff) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   assign out_valid = cam_v_ff;
   assign cam_x     = dx_ff;
   assign cam_y     = dy_ff;

endmodule

`default_nettype wire

### rtl/core/prg_rot.sv
// prg_rot: rotation into world space, three stages (products, sum and round, saturate)
// depends on prg_pkg
`timescale 1ns / 1ps
`default_nettype none

module prg_rot (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire prg_pkg::prg_cfg_type                 cfg,
   input  wire logic                                 in_valid,
   output logic                                      in_ready,
   input  wire logic signed [prg_pkg::CAM_BITS-1:0]  cam_x,
   input  wire logic signed [prg_pkg::CAM_BITS-1:0]  cam_y,
   output logic                                      out_valid,
   input  wire logic                                 out_ready,
   output logic signed [prg_pkg::DIR_BITS-1:0]       dir_x,
   output logic signed [prg_pkg::DIR_BITS-1:0]       dir_y,
   output logic signed [prg_pkg::DIR_BITS-1:0]       dir_z
);
   import prg_pkg::*;

   localparam int QUO_BITS = ACC_BITS - DIR_SHIFT;
   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS =
      $signed(ACC_BITS'(1) << (DIR_SHIFT - 1));

   // round half up already added; floor shift then clamp to q4.12
   function automatic logic signed [DIR_BITS-1:0] sat_dir(
      input logic signed [ACC_BITS-1:0] acc
   );
      logic signed [QUO_BITS-1:0] quo;
      logic [QUO_BITS-DIR_BITS:0] top;
      quo = acc[ACC_BITS-1:DIR_SHIFT];
      top = quo[QUO_BITS-1:DIR_BITS-1];
      if ((top == '0) || (top == '1)) begin
         sat_dir = quo[DIR_BITS-1:0];
      end else if (quo[QUO_BITS-1]) begin
         sat_dir = {1'b1, {(DIR_BITS-1){1'b0}}};
      end else begin
         sat_dir = {1'b0, {(DIR_BITS-1){1'b1}}};
      end
   endfunction

   logic [2:0][47:0]                  rows;
   logic signed [ROT_BITS-1:0]        rx [3];
   logic signed [ROT_BITS-1:0]        ry [3];
   logic signed [ROT_BITS-1:0]        rz [3];

   logic                              prd_v_ff;
   logic                              prd_rdy;
   logic signed [PROD_BITS-1:0]       px_ff [3];
   logic signed [PROD_BITS-1:0]       px_in [3];
   logic signed [PROD_BITS-1:0]       py_ff [3];
   logic signed [PROD_BITS-1:0]       py_in [3];
   logic signed [ROT_BITS-1:0]        rz_ff [3];

   logic                              acc_v_ff;
   logic                              acc_rdy;
   logic signed [ACC_BITS-1:0]        acc_ff [3];
   logic signed [ACC_BITS-1:0]        acc_in [3];

   logic                              out_v_ff;
   logic                              out_rdy;
   logic signed [DIR_BITS-1:0]        dir_ff [3];
   logic signed [DIR_BITS-1:0]        dir_in [3];

   assign rows = {cfg.rot_row2, cfg.rot_row1, cfg.rot_row0};

   assign out_rdy  = !out_v_ff || out_ready;
   assign acc_rdy  = !acc_v_ff || out_rdy;
   assign prd_rdy  = !prd_v_ff || acc_rdy;
   assign in_ready = prd_rdy;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rx[r]     = $signed(rows[r][15:0]);
         ry[r]     = $signed(rows[r][31:16]);
         rz[r]     = $signed(rows[r][47:32]);
         px_in[r]  = PROD_BITS'(rx[r]) * PROD_BITS'(cam_x);
         py_in[r]  = PROD_BITS'(ry[r]) * PROD_BITS'(cam_y);
         // camera z is -1, so its term is the entry shifted up and negated
         acc_in[r] = ACC_BITS'(px_ff[r]) + ACC_BITS'(py_ff[r])
                   - (ACC_BITS'(rz_ff[r]) <<< Z_SHIFT) + ROUND_BIAS;
         dir_in[r] = sat_dir(acc_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prd_v_ff <= 1'b0;
         acc_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (prd_rdy) begin
            prd_v_ff <= in_valid;
         end
         if (acc_rdy) begin
            acc_v_ff <= prd_v_ff;
         end
         if (out_rdy) begin
            out_v_ff <= acc_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         if (prd_rdy && in_valid) begin
            px_ff[r] <= px_in[r];
            py_ff[r] <= py_in[r];
            rz_ff[r] <= rz[r];
         end
         if (acc_rdy && prd_v_ff) begin
            acc_ff[r] <= acc_in[r];
         end
         if (out_rdy && acc_v_ff) begin
            dir_ff[r] <= dir_in[r];
         end
      end
   end

   assign out_valid = out_v_ff;
   assign dir_x     = dir_ff[0];
   assign dir_y     = dir_ff[1];
   assign dir_z     = dir_ff[2];

endmodule

`default_nettype wire

### verif/pinhole_ray_generator_test.sv
// pinhole_ray_generator_test: self-checking bench for the pinhole ray generator
// streams pixel transfers and apb register writes, predicts every ray in fixed point
// depends on prg_pkg and pinhole_ray_generator
`timescale 1ns / 1ps

module pinhole_ray_generator_test;
   import prg_pkg::*;

   localparam int LONG_HOLD_CYCLES = 120;
   localparam int MAX_PRINTED      = 50;

   typedef struct {
      logic signed [15:0] origin_x, origin_y, origin_z;
      logic signed [15:0] dir_x, dir_y, dir_z;
   } ray_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [COORD_BITS-1:0]        req_pixel_row;
   logic [COORD_BITS-1:0]        req_pixel_col;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [15:0]           rsp_origin_x;
   logic signed [15:0]           rsp_origin_y;
   logic signed [15:0]           rsp_origin_z;
   logic signed [DIR_BITS-1:0]   rsp_dir_x;
   logic signed [DIR_BITS-1:0]   rsp_dir_y;
   logic signed [DIR_BITS-1:0]   rsp_dir_z;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]     csr_paddr;
   logic [CSR_DATA_BITS-1:0]     csr_pwdata;
   logic [CSR_DATA_BITS-1:0]     csr_prdata;
   logic                         csr_pready;

   ray_type     expected_rays[$];
   ray_type     due_ray;
   prg_cfg_type cam_cfg;
   int          error_count;
   bit          req_idle_on;
   bit          rsp_idle_on;
   bit          hold_rsp_req;

   pinhole_ray_generator uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel_row (req_pixel_row),
      .req_pixel_col (req_pixel_col),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_origin_x  (rsp_origin_x),
      .rsp_origin_y  (rsp_origin_y),
      .rsp_origin_z  (rsp_origin_z),
      .rsp_dir_x     (rsp_dir_x),
      .rsp_dir_y     (rsp_dir_y),
      .rsp_dir_z     (rsp_dir_z),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   // q.42 dot product, rounded half up to q4.12 and saturated
   function automatic logic signed [15:0] rotate_to_world(logic [47:0] rot_row,
         longint cam_x, longint cam_y, longint cam_z);
      longint acc;
      longint rounded;
      acc = longint'($signed(rot_row[15:0])) * cam_x
          + longint'($signed(rot_row[31:16])) * cam_y
          + longint'($signed(rot_row[47:32])) * cam_z;
      rounded = (acc + (longint'(1) << (DIR_SHIFT - 1))) >>> DIR_SHIFT;
      if (rounded > 32767) return 16'sh7FFF;
      if (rounded < -32768) return 16'sh8000;
      return rounded[15:0];
   endfunction

   function automatic ray_type predict_ray(logic [COORD_BITS-1:0] row,
         logic [COORD_BITS-1:0] col);
      ray_type ray;
      longint  ux, uy, cam_x, cam_y, cam_z;
      ux    = longint'(col) * 16 - longint'(cam_cfg.center_x);
      uy    = longint'(cam_cfg.center_y) - longint'(row) * 16;
      cam_x = ux * longint'(cam_cfg.inv_focal_x);
      cam_y = uy * longint'(cam_cfg.inv_focal_y);
      cam_z = -(longint'(1) << Z_SHIFT);
      ray.origin_x = cam_cfg.translation[15:0];
      ray.origin_y = cam_cfg.translation[31:16];
      ray.origin_z = cam_cfg.translation[47:32];
      ray.dir_x = rotate_to_world(cam_cfg.rot_row0, cam_x, cam_y, cam_z);
      ray.dir_y = rotate_to_world(cam_cfg.rot_row1, cam_x, cam_y, cam_z);
      ray.dir_z = rotate_to_world(cam_cfg.rot_row2, cam_x, cam_y, cam_z);
      return ray;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("error at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(string field, logic signed [15:0] got,
         logic signed [15:0] want);
      if (got !== want) report_error($sformatf("%s got %0d expected %0d", field, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rays.size() == 0) begin
            report_error("ray transfer with no pixel outstanding");
         end else begin
            due_ray = expected_rays.pop_front();
            check_field("origin_x", rsp_origin_x, due_ray.origin_x);
            check_field("origin_y", rsp_origin_y, due_ray.origin_y);
            check_field("origin_z", rsp_origin_z, due_ray.origin_z);
            check_field("dir_x", rsp_dir_x, due_ray.dir_x);
            check_field("dir_y", rsp_dir_y, due_ray.dir_y);
            check_field("dir_z", rsp_dir_z, due_ray.dir_z);
         end
      end
   end

   // ---------------------------------------------------------------- idling

   // mostly short gaps, now and then a long one
   function automatic int pick_gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   initial begin
      int stall_left;
      rsp_ready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = pick_gap_len() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_pixel(logic [COORD_BITS-1:0] row, logic [COORD_BITS-1:0] col);
      int gap;
      gap = (req_idle_on && $urandom_range(0, 3) == 0) ? pick_gap_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_row <= row;
      req_pixel_col <= col;
      do @(posedge clock); while (!req_ready);
      expected_rays.push_back(predict_ray(row, col));
   endtask

   task automatic wait_rays_drained();
      req_valid <= 1'b0;
      while (expected_rays.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [REG_INDEX_BITS-1:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, {REG_WORD_BITS{1'b0}}};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ROT_ROW0:    cam_cfg.rot_row0    = value[47:0];
         REG_ROT_ROW1:    cam_cfg.rot_row1    = value[47:0];
         REG_ROT_ROW2:    cam_cfg.rot_row2    = value[47:0];
         REG_TRANSLATION: cam_cfg.translation = value[47:0];
         REG_CENTER_X:    cam_cfg.center_x    = value[15:0];
         REG_CENTER_Y:    cam_cfg.center_y    = value[15:0];
         REG_INV_FOCAL_X: cam_cfg.inv_focal_x = value[23:0];
         REG_INV_FOCAL_Y: cam_cfg.inv_focal_y = value[23:0];
         default: ;
      endcase
   endtask

   // prdata is sampled at the edge that completes the access phase
   task automatic csr_check_readback(logic [REG_INDEX_BITS-1:0] idx);
      logic [63:0] want;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, {REG_WORD_BITS{1'b0}}};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_ROT_ROW0:    want = 64'(cam_cfg.rot_row0);
         REG_ROT_ROW1:    want = 64'(cam_cfg.rot_row1);
         REG_ROT_ROW2:    want = 64'(cam_cfg.rot_row2);
         REG_TRANSLATION: want = 64'(cam_cfg.translation);
         REG_CENTER_X:    want = 64'(cam_cfg.center_x);
         REG_CENTER_Y:    want = 64'(cam_cfg.center_y);
         REG_INV_FOCAL_X: want = 64'(cam_cfg.inv_focal_x);
         default:         want = 64'(cam_cfg.inv_focal_y);
      endcase
      if (csr_prdata !== want)
         report_error($sformatf("register %0d reads %h expected %h", idx, csr_prdata, want));
   endtask

   // random junk above the register width must be dropped
   function automatic logic [63:0] junk_above(logic [63:0] value, int width);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      return (noise << width) | value;
   endfunction

   task automatic load_camera(logic [47:0] rot0, logic [47:0] rot1, logic [47:0] rot2,
         logic [47:0] origin, logic [15:0] cx, logic [15:0] cy,
         logic [23:0] inv_fx, logic [23:0] inv_fy);
      wait_rays_drained();
      csr_write(REG_ROT_ROW0, junk_above(64'(rot0), 48));
      csr_write(REG_ROT_ROW1, junk_above(64'(rot1), 48));
      csr_write(REG_ROT_ROW2, junk_above(64'(rot2), 48));
      csr_write(REG_TRANSLATION, junk_above(64'(origin), 48));
      csr_write(REG_CENTER_X, junk_above(64'(cx), 16));
      csr_write(REG_CENTER_Y, junk_above(64'(cy), 16));
      csr_write(REG_INV_FOCAL_X, junk_above(64'(inv_fx), 24));
      csr_write(REG_INV_FOCAL_Y, junk_above(64'(inv_fy), 24));
   endtask

   // ---------------------------------------------------------------- random picks

   function automatic logic [15:0] pick_rot_entry();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic logic [47:0] pick_rot_row();
      return {pick_rot_entry(), pick_rot_entry(), pick_rot_entry()};
   endfunction

   // focal lengths of roughly 64 to 4096 pixels keep most rays in range
   function automatic logic [23:0] pick_inv_focal();
      case ($urandom_range(0, 9))
         0:       return 24'd0;
         1:       return 24'hFFFFFF;
         2:       return 24'($urandom);
         default: return 24'($urandom_range(4096, 262144));
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   task automatic randomise_camera();
      load_camera(pick_rot_row(), pick_rot_row(), pick_rot_row(), 48'({$urandom, $urandom}),
                  16'($urandom), 16'($urandom), pick_inv_focal(), pick_inv_focal());
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_state();
      for (int idx = 0; idx < 8; idx++) csr_check_readback(REG_INDEX_BITS'(idx));
      // principal point 200.0 lands on the optical axis
      send_pixel(12'd200, 12'd200);
      send_pixel(12'd199, 12'd201);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
   endtask

   task automatic test_register_access();
      wait_rays_drained();
      csr_write(REG_ROT_ROW0, {$urandom, $urandom});
      csr_write(REG_ROT_ROW1, {$urandom, $urandom});
      csr_write(REG_ROT_ROW2, {$urandom, $urandom});
      csr_write(REG_TRANSLATION, {$urandom, $urandom});
      csr_write(REG_CENTER_X, {$urandom, $urandom});
      csr_write(REG_CENTER_Y, {$urandom, $urandom});
      csr_write(REG_INV_FOCAL_X, {$urandom, $urandom});
      csr_write(REG_INV_FOCAL_Y, {$urandom, $urandom});
      for (int idx = 0; idx < 8; idx++) csr_check_readback(REG_INDEX_BITS'(idx));
   endtask

   task automatic test_direction_extremes();
      // full-scale rotation and reciprocals drive several components into saturation
      load_camera({3{16'h7FFF}}, {3{16'h8000}}, {16'h7FFF, 16'h8000, 16'h0000},
                  {16'h8000, 16'h7FFF, 16'hFFFF}, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      load_camera({3{16'h8000}}, {16'h0000, 16'h7FFF, 16'h8000}, {3{16'h7FFF}},
                  {16'h7FFF, 16'h8000, 16'h0001}, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'd1);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd2048, 12'd1);
      // zero reciprocals leave only the optical axis term
      load_camera(pick_rot_row(), pick_rot_row(), pick_rot_row(), 48'hFFFF_FFFF_FFFF,
                  16'h1234, 16'hFFFF, 24'd0, 24'd0);
      send_pixel(12'd123, 12'd456);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         randomise_camera();
         // first phase runs flat out on both sides
         req_idle_on = (phase == 1 || phase == 2 || phase >= 4);
         rsp_idle_on = (phase == 1 || phase == 3 || phase >= 4);
         repeat (130) send_pixel(pick_coord(), pick_coord());
      end
   endtask

   task automatic test_output_stall();
      randomise_camera();
      req_idle_on  = 1'b0;
      rsp_idle_on  = 1'b1;
      hold_rsp_req = 1'b1;
      // keep offering while the output is held so the pipeline backs up
      repeat (48) send_pixel(pick_coord(), pick_coord());
      wait_rays_drained();
   endtask

   task automatic test_drain_pause();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (20) send_pixel(pick_coord(), pick_coord());
      wait_rays_drained();
      repeat (20) send_pixel(pick_coord(), pick_coord());
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pixel_row = '0;
      req_pixel_col = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      error_count   = 0;
      req_idle_on   = 1'b0;
      rsp_idle_on   = 1'b0;
      hold_rsp_req  = 1'b0;
      cam_cfg.rot_row0    = ROT_ROW0_RESET;
      cam_cfg.rot_row1    = ROT_ROW1_RESET;
      cam_cfg.rot_row2    = ROT_ROW2_RESET;
      cam_cfg.translation = TRANSLATION_RESET;
      cam_cfg.center_x    = CENTER_RESET;
      cam_cfg.center_y    = CENTER_RESET;
      cam_cfg.inv_focal_x = INV_FOCAL_RESET;
      cam_cfg.inv_focal_y = INV_FOCAL_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_register_access();
      test_direction_extremes();
      test_random_traffic();
      test_output_stall();
      test_drain_pause();

      wait_rays_drained();
      // a stray ray would show up within the pipeline depth
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_rays.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
